@@ sv/msgpack_record_frame_encoder_defines.svh @@
// ----------------------------------------------------------------------------
// MessagePack record frame encoder: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MSGPACK_RECORD_FRAME_ENCODER_DEFINES_SVH
`define MSGPACK_RECORD_FRAME_ENCODER_DEFINES_SVH

// Same-cycle implication.
`define MRFE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MRFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/mrfe_pkg.sv @@
// ----------------------------------------------------------------------------
// MessagePack record frame encoder package
// Field widths, MessagePack codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mrfe_pkg;

  localparam int ValueCount = 6;
  localparam int ValueWidth = 64;
  localparam int SlotWidth  = 3;
  localparam int InWidth    = ValueCount * ValueWidth;

  localparam logic [7:0] FixintMax    = 8'h7f;
  localparam logic [7:0] TagU8        = 8'hcc;
  localparam logic [7:0] TagU16       = 8'hcd;
  localparam logic [7:0] TagU32       = 8'hce;
  localparam logic [7:0] TagU64       = 8'hcf;
  localparam logic [7:0] FixarrayBase = 8'h90;
  localparam logic [7:0] ArrayHeader  = FixarrayBase | 8'(ValueCount);

  // payload = array header + one tag byte per value + body bytes
  localparam logic [5:0] PayloadBase  = 6'(1 + ValueCount);
  localparam logic [SlotWidth-1:0] LastSlot = SlotWidth'(ValueCount - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LEN  = 5'b00010,
    S_HDR  = 5'b00100,
    S_TAG  = 5'b01000,
    S_BODY = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    SEL_LEN  = 2'd0,
    SEL_HDR  = 2'd1,
    SEL_TAG  = 2'd2,
    SEL_BODY = 2'd3
  } sel_t;

  typedef struct packed {
    logic                 load;
    logic                 emit;
    sel_t                 sel;
    logic [SlotWidth-1:0] slot;
    logic [2:0]           idx;
    logic                 last;
  } cmd_t;

  typedef struct packed {
    logic [3:0] body_len;
    logic       out_free;
  } sts_t;

  // Bytes after the tag byte: 0 for a fixint, else 1, 2, 4 or 8.
  function automatic logic [3:0] body_len(input logic [ValueWidth-1:0] v);
    logic [3:0] n;
    if (v <= ValueWidth'(FixintMax))       n = 4'd0;
    else if (v[ValueWidth-1:8] == '0)      n = 4'd1;
    else if (v[ValueWidth-1:16] == '0)     n = 4'd2;
    else if (v[ValueWidth-1:32] == '0)     n = 4'd4;
    else                                   n = 4'd8;
    return n;
  endfunction

endpackage

`default_nettype wire

@@ sv/mrfe_ctrl.sv @@
// ----------------------------------------------------------------------------
// MessagePack record frame encoder: controller
// Sequences length prefix, array header, tag and body bytes of a frame,
// one word per cycle whenever the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfe_ctrl
  import mrfe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t               state, state_next;
  logic [3:0]           cnt, cnt_next;
  logic [SlotWidth-1:0] slot, slot_next;
  logic [3:0]           cnt_dec;

  assign in_ready = (state == S_IDLE);
  assign cnt_dec  = cnt - 4'd1;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    slot_next  = slot;
    cmd        = '0;
    cmd.slot   = slot;
    cmd.sel    = SEL_LEN;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          slot_next  = '0;
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        cmd.sel = SEL_LEN;
        cmd.idx = cnt[2:0];
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cnt_next = cnt + 4'd1;
          if (cnt == 4'd3) state_next = S_HDR;
        end
      end
      S_HDR: begin
        cmd.sel = SEL_HDR;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          slot_next  = '0;
          state_next = S_TAG;
        end
      end
      S_TAG: begin
        cmd.sel  = SEL_TAG;
        cmd.last = (sts.body_len == 4'd0) && (slot == LastSlot);
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.body_len != 4'd0) begin
            cnt_next   = sts.body_len;
            state_next = S_BODY;
          end else if (slot == LastSlot) begin
            state_next = S_IDLE;
          end else begin
            slot_next = slot + 1'b1;
          end
        end
      end
      S_BODY: begin
        // big-endian: the remaining count picks the byte
        cmd.sel  = SEL_BODY;
        cmd.idx  = cnt_dec[2:0];
        cmd.last = (cnt == 4'd1) && (slot == LastSlot);
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cnt_next = cnt_dec;
          if (cnt == 4'd1) begin
            if (slot == LastSlot) begin
              state_next = S_IDLE;
            end else begin
              slot_next  = slot + 1'b1;
              state_next = S_TAG;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      slot  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      slot  <= slot_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/mrfe_dp.sv @@
// ----------------------------------------------------------------------------
// MessagePack record frame encoder: datapath
// Holds the record, its encoded lengths and payload size, selects the
// next frame byte and keeps the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfe_dp
  import mrfe_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [InWidth-1:0] rec,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_byte,
  output logic                    out_last
);

  logic [ValueWidth-1:0] vals [ValueCount];
  logic [3:0]            lens [ValueCount];
  logic [5:0]            payload;
  logic [5:0]            payload_next;
  logic [3:0]            cur_len;
  logic [ValueWidth-1:0] cur_val;
  logic [7:0]            tag_byte;
  logic [7:0]            byte_next;

  assign cur_len      = lens[cmd.slot];
  assign cur_val      = vals[cmd.slot];
  assign sts.body_len = cur_len;
  assign sts.out_free = !out_valid || out_ready;

  always_comb begin
    payload_next = PayloadBase;
    for (int i = 0; i < ValueCount; i++) begin
      payload_next = payload_next + {2'b00, body_len(rec[i*ValueWidth +: ValueWidth])};
    end
  end

  always_comb begin
    case (cur_len)
      4'd1:    tag_byte = TagU8;
      4'd2:    tag_byte = TagU16;
      4'd4:    tag_byte = TagU32;
      4'd8:    tag_byte = TagU64;
      default: tag_byte = cur_val[7:0];
    endcase
  end

  always_comb begin
    case (cmd.sel)
      SEL_LEN:  byte_next = (cmd.idx[1:0] == 2'd3) ? {2'b00, payload} : 8'h00;
      SEL_HDR:  byte_next = ArrayHeader;
      SEL_TAG:  byte_next = tag_byte;
      SEL_BODY: byte_next = cur_val[{cmd.idx, 3'b000} +: 8];
      default:  byte_next = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      payload <= payload_next;
      for (int i = 0; i < ValueCount; i++) begin
        vals[i] <= rec[i*ValueWidth +: ValueWidth];
        lens[i] <= body_len(rec[i*ValueWidth +: ValueWidth]);
      end
    end
    if (cmd.emit) begin
      out_byte <= byte_next;
      out_last <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ sv/msgpack_record_frame_encoder.sv @@
// A record of six 64-bit unsigned values is taken in one word and sent out
// as one frame, one byte per word: a 4-byte big-endian payload length, the
// fixarray header 0x96, then each value as the shortest MessagePack
// unsigned integer (fixint, or 0xcc/0xcd/0xce/0xcf with 1, 2, 4 or 8
// big-endian body bytes). tlast marks the final byte. A frame of N bytes
// (11 to 59) leaves at one byte per cycle from the byte sequencer whenever
// the output register is free, and a new record is taken only once the
// final byte has been issued. The next record is accepted while the final
// byte still sits in the output register.
// ----------------------------------------------------------------------------
// MessagePack record frame encoder: top level
// Joins the frame controller and the byte datapath to the stream ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "msgpack_record_frame_encoder_defines.svh"

module msgpack_record_frame_encoder
  import mrfe_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // cluster_id[63:0], event_kind[127:64], event_number[191:128],
  // event_total[255:192], start_stamp[319:256], end_stamp[383:320]
  input  wire logic [InWidth-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // out_byte[7:0]
  output logic [7:0]              m_axis_tdata,
  output logic                    m_axis_tlast
);

  cmd_t cmd;
  sts_t sts;

  mrfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mrfe_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .rec       (s_axis_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

  `MRFE_ASSERT_NOW(a_no_emit_when_idle, clk, rst, s_axis_tready, !cmd.emit, "byte emitted while idle")
  `MRFE_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.emit, (!m_axis_tvalid || m_axis_tready), "waiting word overwritten")
  `MRFE_ASSERT_NEXT(a_busy_after_load, clk, rst, (s_axis_tvalid && s_axis_tready), (!s_axis_tready && !m_axis_tlast || !s_axis_tready && !cmd.last), "record taken while framing")

endmodule

`default_nettype wire
